// ===== hdl/btns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btns_pkg
// Shared codes, state and command types for the B-tree node table core.
// ----------------------------------------------------------------------------
package btns_pkg;

  // command codes carried by an input beat
  localparam logic [2:0] CMD_RESOLVE = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_REMOVE  = 3'd2;
  localparam logic [2:0] CMD_UPDATE  = 3'd3;
  localparam logic [2:0] CMD_REBIND  = 3'd4;
  localparam logic [2:0] CMD_CLEAR   = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_INNER = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUTE,
    S_SEARCH,
    S_SCAN,
    S_APPLY,
    S_APPLY2,
    S_DONE
  } state_t;

  // datapath operation issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH,
    OP_SCAN,
    OP_APPLY,
    OP_APPLY2,
    OP_EMIT
  } op_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       is_leaf;
    logic       full;
    logic       empty;
    logic       srch_done;
    logic       scan_done;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/btns_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btns_ctrl
// Sequencer: takes an input beat, walks search or scan where needed, applies, emits.
// ----------------------------------------------------------------------------
module btns_ctrl
  import btns_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t st,
  output op_t             op
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ROUTE;
      end
      S_ROUTE: begin
        unique case (st.cmd)
          CMD_RESOLVE: state_next = S_SEARCH;
          CMD_INSERT:  state_next = st.full ? S_APPLY : S_SEARCH;
          CMD_REMOVE:  state_next = st.is_leaf ? S_SEARCH : S_APPLY;
          CMD_UPDATE:  state_next = S_SCAN;
          CMD_REBIND:  state_next = (st.full || st.empty) ? S_APPLY : S_SCAN;
          default:     state_next = S_APPLY;
        endcase
      end
      S_SEARCH: begin
        if (st.srch_done) state_next = S_APPLY;
      end
      S_SCAN: begin
        if (st.scan_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        if (st.cmd == CMD_REBIND && !st.full && st.empty) state_next = S_APPLY2;
        else state_next = S_DONE;
      end
      S_APPLY2: state_next = S_DONE;
      S_DONE: begin
        if (st.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    op       = OP_NONE;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) op = OP_LOAD;
      end
      S_ROUTE:  op = OP_NONE;
      S_SEARCH: op = st.srch_done ? OP_NONE : OP_SRCH;
      S_SCAN:   op = st.scan_done ? OP_NONE : OP_SCAN;
      S_APPLY:  op = OP_APPLY;
      S_APPLY2: op = OP_APPLY2;
      S_DONE:   op = st.out_free ? OP_EMIT : OP_NONE;
      default:  op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/btns_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btns_datapath
// Key and child rows, search/scan registers, row shifts and output register.
// ----------------------------------------------------------------------------
module btns_datapath
  import btns_pkg::*;
#(
  parameter int MAX_KEYS = 15,
  parameter int REF_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire op_t         op,
  output dp_status_t       st,
  input  wire logic [2:0]  command,
  input  wire logic [63:0] search_key,
  input  wire logic [63:0] child_ref,
  input  wire logic [63:0] second_ref,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [63:0]      result_ref,
  output logic [4:0]       slot_index,
  output logic [3:0]       key_count,
  output logic             node_full,
  output logic [1:0]       status
);

  localparam int SW  = $clog2(MAX_KEYS + 2);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int KIW = $clog2(MAX_KEYS);
  localparam int CIW = $clog2(MAX_KEYS + 1);
  localparam int NC  = MAX_KEYS + 1;

  logic [63:0]         key_row   [MAX_KEYS];
  logic [REF_BITS-1:0] child_row [NC];
  logic [63:0]         key_n     [MAX_KEYS];
  logic [REF_BITS-1:0] child_n   [NC];
  logic [CW-1:0]       used, used_n;
  logic                is_leaf;

  // latched beat
  logic [2:0]          cmd_r;
  logic [63:0]         key_r;
  logic [REF_BITS-1:0] r1, r2;

  // search / scan registers
  logic [SW-1:0] lo, hi;
  logic          hit;
  logic [SW:0]   mid_sum;
  logic [SW-1:0] mid, key_addr;
  logic [63:0]   key_rd;
  logic [REF_BITS-1:0] child_rd;

  // result of the apply step
  logic          res_found, rf_n;
  logic [SW-1:0] res_slot, rs_n;
  logic [1:0]    res_status, rst_n;
  logic [REF_BITS-1:0] res_ref, rr_n;

  logic [SW-1:0] used_s;
  logic          full, empty, gt_mode;

  assign used_s  = SW'(used);
  assign full    = (used == CW'(MAX_KEYS));
  assign empty   = (used == '0);
  assign gt_mode = (cmd_r == CMD_RESOLVE) && !is_leaf;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[SW:1];
  assign key_addr = (op == OP_SRCH) ? mid : lo;
  assign key_rd   = key_row[key_addr[KIW-1:0]];
  assign child_rd = child_row[lo[CIW-1:0]];

  assign st.cmd       = cmd_r;
  assign st.is_leaf   = is_leaf;
  assign st.full      = full;
  assign st.empty     = empty;
  assign st.srch_done = hit || (lo >= hi);
  assign st.scan_done = hit || (lo > used_s);
  assign st.out_free  = !out_valid || !out_stall;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      is_leaf <= 1'b1;
    end else if (cfg_valid) begin
      is_leaf <= cfg_data;
    end
  end

  // beat latch, search and scan stepping
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      lo  <= '0;
      hi  <= '0;
    end else begin
      unique case (op)
        OP_LOAD: begin
          hit <= 1'b0;
          lo  <= '0;
          hi  <= used_s;
        end
        OP_SRCH: begin
          if (key_r < key_rd) begin
            hi <= mid;
          end else if (key_r > key_rd || gt_mode) begin
            lo <= mid + SW'(1);
          end else begin
            hit <= 1'b1;
            lo  <= mid;
          end
        end
        OP_SCAN: begin
          if (child_rd == r1) hit <= 1'b1;
          else lo <= lo + SW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      cmd_r <= command;
      key_r <= search_key;
      r1    <= child_ref[REF_BITS-1:0];
      r2    <= second_ref[REF_BITS-1:0];
    end
  end

  // row update for apply steps
  always_comb begin
    key_n   = key_row;
    child_n = child_row;
    used_n  = used;
    rf_n    = 1'b0;
    rs_n    = '0;
    rst_n   = ST_OK;
    rr_n    = '0;
    if (op == OP_APPLY) begin
      case (cmd_r)
        CMD_RESOLVE: begin
          if (is_leaf) begin
            rf_n = hit;
            rs_n = hit ? lo : used_s;
            rr_n = hit ? child_rd : '0;
          end else begin
            rf_n = 1'b1;
            rs_n = lo;
            rr_n = child_rd;
          end
        end
        CMD_INSERT: begin
          if (full) begin
            rst_n = ST_FULL;
          end else begin
            rs_n = lo;
            if (lo < used_s && key_rd == key_r) begin
              rf_n = 1'b1;
              for (int j = 0; j < NC; j++) begin
                if (SW'(j) == lo) child_n[j] = r1;
              end
            end else begin
              for (int j = 0; j < NC; j++) begin
                if (SW'(j) == lo) child_n[j] = r1;
                else if (SW'(j) > lo && SW'(j) <= used_s + SW'(1)) begin
                  child_n[j] = child_row[(j + NC - 1) % NC];
                end
              end
              for (int j = 0; j < MAX_KEYS; j++) begin
                if (SW'(j) == lo) key_n[j] = key_r;
                else if (SW'(j) > lo && SW'(j) <= used_s) begin
                  key_n[j] = key_row[(j + MAX_KEYS - 1) % MAX_KEYS];
                end
              end
              used_n = used + CW'(1);
            end
          end
        end
        CMD_REMOVE: begin
          if (!is_leaf) begin
            rst_n = ST_INNER;
          end else if (hit) begin
            rf_n = 1'b1;
            rs_n = lo;
            for (int j = 0; j < NC; j++) begin
              if (SW'(j) == used_s) child_n[j] = '0;
              else if (j < NC - 1 && SW'(j) >= lo && SW'(j) < used_s) begin
                child_n[j] = child_row[(j + 1) % NC];
              end
            end
            for (int j = 0; j < MAX_KEYS; j++) begin
              if (SW'(j) + SW'(1) == used_s) key_n[j] = '0;
              else if (j < MAX_KEYS - 1 && SW'(j) >= lo && SW'(j) + SW'(1) < used_s) begin
                key_n[j] = key_row[(j + 1) % MAX_KEYS];
              end
            end
            used_n = used - CW'(1);
          end else begin
            rs_n = used_s;
          end
        end
        CMD_UPDATE: begin
          rs_n = lo;
          if (hit) begin
            rf_n = 1'b1;
            for (int j = 0; j < NC; j++) begin
              if (SW'(j) == lo) child_n[j] = r2;
            end
          end
        end
        CMD_REBIND: begin
          if (full) begin
            rst_n = ST_FULL;
          end else if (empty) begin
            // first half: left child at slot 0, key at slot 0
            rf_n = 1'b1;
            child_n[0] = r1;
            child_n[1] = child_row[0];
            key_n[0]   = key_r;
            used_n     = CW'(1);
          end else begin
            rs_n = lo;
            if (hit) begin
              rf_n = 1'b1;
              for (int j = 0; j < NC; j++) begin
                if (SW'(j) == lo + SW'(1)) child_n[j] = r2;
                else if (SW'(j) > lo + SW'(1) && SW'(j) <= used_s + SW'(1)) begin
                  child_n[j] = child_row[(j + NC - 1) % NC];
                end
              end
              for (int j = 0; j < MAX_KEYS; j++) begin
                if (SW'(j) == lo) key_n[j] = key_r;
                else if (SW'(j) > lo && SW'(j) <= used_s) begin
                  key_n[j] = key_row[(j + MAX_KEYS - 1) % MAX_KEYS];
                end
              end
              used_n = used + CW'(1);
            end
          end
        end
        CMD_CLEAR: begin
          for (int j = 0; j < NC; j++) child_n[j] = '0;
          for (int j = 0; j < MAX_KEYS; j++) key_n[j] = '0;
          used_n = '0;
        end
        default: ;
      endcase
    end else if (op == OP_APPLY2) begin
      // second half of empty rebind: right child at slot 1 with one key held
      for (int j = 1; j < NC; j++) begin
        if (j == 1) child_n[j] = r2;
        else if (SW'(j) <= used_s + SW'(1)) child_n[j] = child_row[j-1];
      end
    end
  end

  // rows and key count
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      for (int j = 0; j < NC; j++) child_row[j] <= '0;
      for (int j = 0; j < MAX_KEYS; j++) key_row[j] <= '0;
    end else begin
      used      <= used_n;
      child_row <= child_n;
      key_row   <= key_n;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_APPLY) begin
      res_found  <= rf_n;
      res_slot   <= rs_n;
      res_status <= rst_n;
      res_ref    <= rr_n;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT) begin
      found      <= res_found;
      result_ref <= 64'(res_ref);
      slot_index <= 5'(res_slot);
      key_count  <= 4'(used);
      node_full  <= full;
      status     <= res_status;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/btree_node_sorted_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btree_node_sorted_table_core
// One B-tree node: sorted key row plus child row, with lookup and edit commands.
// ----------------------------------------------------------------------------
// One command beat is taken at a time and gives one result beat. A beat takes
// a load step, a routing step, then a binary search over the keys (one probe a
// cycle), a linear scan of the children (one child a cycle) or neither, an
// apply step (followed by an APPLY2 step for rebind on an empty node) and an
// emit step. Shifts on insert, remove and rebind happen in the apply steps.
// The result register lets the next beat start while a result waits. The
// is_leaf register is written through the config channel, always ready.
// ----------------------------------------------------------------------------
module btree_node_sorted_table_core
  import btns_pkg::*;
#(
  parameter int MAX_KEYS = 15,
  parameter int REF_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  command,
  input  wire logic [63:0] search_key,
  input  wire logic [63:0] child_ref,
  input  wire logic [63:0] second_ref,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [63:0]      result_ref,
  output logic [4:0]       slot_index,
  output logic [3:0]       key_count,
  output logic             node_full,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);

  op_t        op;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  btns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .op       (op)
  );

  btns_datapath #(
    .MAX_KEYS (MAX_KEYS),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .st         (st),
    .command    (command),
    .search_key (search_key),
    .child_ref  (child_ref),
    .second_ref (second_ref),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .result_ref (result_ref),
    .slot_index (slot_index),
    .key_count  (key_count),
    .node_full  (node_full),
    .status     (status)
  );

endmodule
`default_nettype wire

// ===== dv/tb_btree_node_sorted_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_btree_node_sorted_table_core
// Self-checking bench for the B-tree node table core: a behavioural node model
// predicts each result beat, which is compared with the arriving beat.
// ----------------------------------------------------------------------------
module tb_btree_node_sorted_table_core;
  import btns_pkg::*;

  localparam int NKEYS = 15;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        found;
    logic [63:0] rref;
    logic [4:0]  slot;
    logic [3:0]  cnt;
    logic        full;
    logic [1:0]  st;
  } node_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic [63:0] search_key = '0, child_ref = '0, second_ref = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic found;
  logic [63:0] result_ref;
  logic [4:0] slot_index;
  logic [3:0] key_count;
  logic node_full;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  btree_node_sorted_table_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .search_key(search_key),
    .child_ref(child_ref), .second_ref(second_ref),
    .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .result_ref(result_ref), .slot_index(slot_index),
    .key_count(key_count), .node_full(node_full), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // model state
  logic [63:0] m_keys [NKEYS];
  logic [63:0] m_kids [NKEYS+1];
  int unsigned m_used;
  logic        m_leaf;

  node_result_t pending_results [$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;   // percent
  int recv_idle = 0;

  function automatic int unsigned key_find(logic [63:0] k, int mode);
    // mode 0 lower bound, 1 exact, 2 upper bound
    int unsigned lo, hi, mid;
    lo = 0; hi = m_used;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (k < m_keys[mid]) hi = mid;
      else if (k > m_keys[mid] || mode == 2) lo = mid + 1;
      else return mid;
    end
    return (mode == 1) ? m_used : lo;
  endfunction

  function automatic int unsigned kid_find(logic [63:0] r);
    for (int unsigned i = 0; i <= m_used; i++)
      if (m_kids[i] == r) return i;
    return m_used + 1;
  endfunction

  function automatic void kid_open(int unsigned at, logic [63:0] r);
    for (int unsigned i = m_used + 1; i > at; i--) m_kids[i] = m_kids[i-1];
    m_kids[at] = r;
  endfunction

  function automatic void key_open(int unsigned at, logic [63:0] k);
    for (int unsigned i = m_used; i > at; i--) m_keys[i] = m_keys[i-1];
    m_keys[at] = k;
    m_used++;
  endfunction

  function automatic void node_clear();
    for (int i = 0; i < NKEYS; i++) m_keys[i] = '0;
    for (int i = 0; i <= NKEYS; i++) m_kids[i] = '0;
    m_used = 0;
  endfunction

  function automatic node_result_t node_apply(logic [2:0] c, logic [63:0] k,
                                              logic [63:0] r1, logic [63:0] r2);
    node_result_t res;
    int unsigned s;
    res = '0;
    s = 0;
    case (c)
      CMD_RESOLVE: begin
        if (m_leaf) begin
          s = key_find(k, 1);
          if (s < m_used) begin
            res.found = 1'b1;
            res.rref = m_kids[s];
          end
        end else begin
          s = key_find(k, 2);
          res.found = 1'b1;
          res.rref = m_kids[s];
        end
      end
      CMD_INSERT: begin
        if (m_used >= NKEYS) res.st = ST_FULL;
        else begin
          s = key_find(k, 0);
          if (s < m_used && m_keys[s] == k) begin
            m_kids[s] = r1;
            res.found = 1'b1;
          end else begin
            kid_open(s, r1);
            key_open(s, k);
          end
        end
      end
      CMD_REMOVE: begin
        if (!m_leaf) res.st = ST_INNER;
        else begin
          s = key_find(k, 1);
          if (s < m_used) begin
            res.found = 1'b1;
            for (int unsigned i = s + 1; i <= m_used; i++) m_kids[i-1] = m_kids[i];
            m_kids[m_used] = '0;
            for (int unsigned i = s + 1; i < m_used; i++) m_keys[i-1] = m_keys[i];
            m_keys[m_used-1] = '0;
            m_used--;
          end
        end
      end
      CMD_UPDATE: begin
        s = kid_find(r1);
        if (s <= m_used) begin
          m_kids[s] = r2;
          res.found = 1'b1;
        end
      end
      CMD_REBIND: begin
        if (m_used >= NKEYS) res.st = ST_FULL;
        else if (m_used == 0) begin
          kid_open(0, r1);
          key_open(0, k);
          kid_open(1, r2);
          res.found = 1'b1;
        end else begin
          s = kid_find(r1);
          if (s <= m_used) begin
            kid_open(s + 1, r2);
            key_open(s, k);
            res.found = 1'b1;
          end
        end
      end
      CMD_CLEAR: node_clear();
      default: ;
    endcase
    res.slot = s[4:0];
    res.cnt  = m_used[3:0];
    res.full = (m_used == NKEYS);
    return res;
  endfunction

  // one command beat; predicts on acceptance, valid stays up for the next beat
  task automatic send_command(logic [2:0] c, logic [63:0] k,
                              logic [63:0] r1, logic [63:0] r2);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= c;
    search_key <= k;
    child_ref  <= r1;
    second_ref <= r2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(node_apply(c, k, r1, r2));
  endtask

  // drops valid, waits for all results, lets the core settle, then writes is_leaf
  task automatic set_leaf_mode(logic v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_leaf = v;
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  // result checker
  always @(posedge clk) begin
    node_result_t got, want;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = {found, result_ref, slot_index, key_count, node_full, status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp f=%b r=%h s=%0d n=%0d full=%b st=%0d",
                      " / got f=%b r=%h s=%0d n=%0d full=%b st=%0d"},
                     want.found, want.rref, want.slot, want.cnt, want.full, want.st,
                     got.found, got.rref, got.slot, got.cnt, got.full, got.st);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("btree_node_sorted_table_core verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // keys from a small pool so hits are common, with some wide values
  function automatic logic [63:0] pick_key();
    case ($urandom_range(3))
      0: return rand64();
      1: return {60'd0, 4'($urandom_range(15))} * 64'd3;
      default: return 64'($urandom_range(40));
    endcase
  endfunction

  function automatic logic [63:0] pick_kid();
    if ($urandom_range(2) == 0 && m_used > 0) return m_kids[$urandom_range(m_used)];
    if ($urandom_range(5) == 0) return rand64();
    return 64'($urandom_range(60));
  endfunction

  task automatic test_directed_leaf();
    send_command(CMD_RESOLVE, 64'd5, 64'd0, 64'd0);
    send_command(CMD_REMOVE, 64'd5, 64'd0, 64'd0);
    send_command(CMD_INSERT, 64'd0, 64'd11, 64'd0);            // null key
    send_command(CMD_INSERT, '1, '1, '1);
    send_command(CMD_INSERT, 64'h8000_0000_0000_0000, 64'd22, 64'd0);
    send_command(CMD_INSERT, '1, 64'd33, 64'd0);                // overwrite
    send_command(CMD_RESOLVE, '1, 64'd0, 64'd0);
    send_command(CMD_RESOLVE, 64'd7, 64'd0, 64'd0);
    send_command(CMD_UPDATE, 64'd0, 64'd22, 64'hdead);
    send_command(CMD_UPDATE, 64'd0, 64'd999, 64'd1);            // no match
    send_command(CMD_REBIND, 64'd100, 64'hdead, 64'd44);
    send_command(CMD_REBIND, 64'd100, 64'd999, 64'd44);         // left absent
    send_command(CMD_REMOVE, 64'd0, 64'd0, 64'd0);
    send_command(CMD_REMOVE, 64'd77, 64'd0, 64'd0);
    send_command(3'd6, rand64(), rand64(), rand64());
    send_command(3'd7, rand64(), rand64(), rand64());
    // fill to capacity, then refused insert and rebind
    for (int i = 0; i < 16; i++) send_command(CMD_INSERT, 64'(i * 7 + 1), 64'(i + 1), 64'd0);
    send_command(CMD_REBIND, 64'd3, 64'd1, 64'd2);
    send_command(CMD_CLEAR, 64'd0, 64'd0, 64'd0);
    send_command(CMD_REBIND, 64'd50, 64'd1, 64'd2);             // empty node rebind
  endtask

  task automatic test_directed_inner();
    set_leaf_mode(1'b0);
    send_command(CMD_RESOLVE, 64'd0, 64'd0, 64'd0);
    send_command(CMD_RESOLVE, 64'd50, 64'd0, 64'd0);
    send_command(CMD_RESOLVE, '1, 64'd0, 64'd0);
    send_command(CMD_REMOVE, 64'd50, 64'd0, 64'd0);
    send_command(CMD_REBIND, 64'd80, 64'd2, 64'd3);
    send_command(CMD_RESOLVE, 64'd79, 64'd0, 64'd0);
  endtask

  task automatic test_random(int n, logic leaf);
    int r;
    set_leaf_mode(leaf);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 30) send_command(CMD_RESOLVE, pick_key(), rand64(), rand64());
      else if (r < 55) send_command(CMD_INSERT, pick_key(), pick_kid(), rand64());
      else if (r < 70) send_command(CMD_REMOVE, pick_key(), rand64(), rand64());
      else if (r < 80) send_command(CMD_UPDATE, pick_key(), pick_kid(), pick_kid());
      else if (r < 92) send_command(CMD_REBIND, pick_key(), pick_kid(), pick_kid());
      else if (r < 96) send_command(CMD_CLEAR, rand64(), rand64(), rand64());
      else send_command(3'($urandom_range(7)), rand64(), rand64(), rand64());
    end
  endtask

  initial begin
    node_clear();
    m_leaf = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle = 12; recv_idle = 61;
    test_directed_leaf();
    test_directed_inner();
    test_random(90, 1'b1);
    test_random(90, 1'b0);
    send_idle = 61; recv_idle = 12;
    test_random(90, 1'b1);
    test_random(90, 1'b0);
    send_idle = 0; recv_idle = 0;
    test_random(90, 1'b1);
    test_random(60, 1'b0);
    set_leaf_mode(1'b1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("btree_node_sorted_table_core verification clean");
    else
      $display("btree_node_sorted_table_core verification failed");
    $finish;
  end

endmodule
